// ===== src/mfpl_pkg.sv =====
// Package for the motor fader position loop.
// Holds shared types, codes and constants; depends on nothing else.

package mfpl_pkg;

  // Default widths handed to the top-level parameters.
  localparam int ADC_BITS_DEF = 10;
  localparam int SUM_BITS_DEF = 24;

  // Configuration port geometry.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_P    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_I    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_D    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_OUT_LIMIT = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_DEAD_BAND = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_DUTY  = 3'd5;

  // Register reset values.
  localparam logic [15:0] GAIN_P_RST    = 16'd256;
  localparam logic [15:0] GAIN_I_RST    = 16'd0;
  localparam logic [15:0] GAIN_D_RST    = 16'd0;
  localparam logic [7:0]  OUT_LIMIT_RST = 8'd255;
  localparam logic [7:0]  DEAD_BAND_RST = 8'd5;
  localparam logic [7:0]  MIN_DUTY_RST  = 8'd100;

  // Highest accepted target position.
  localparam logic [7:0] TARGET_MAX = 8'd128;

  // Result channel data width: drive, duty and position, padded to bytes.
  localparam int OUT_DATA_W = 24;

  // Item kinds carried on the input tuser.
  localparam logic MODE_TICK   = 1'b0;
  localparam logic MODE_TARGET = 1'b1;

  // Motor direction codes.
  typedef enum logic [1:0] {
    DRIVE_STOP = 2'd0,
    DRIVE_UP   = 2'd1,
    DRIVE_DOWN = 2'd2
  } drive_t;

  // Operand select for the shared multiplier.
  typedef enum logic [1:0] {
    MUL_P = 2'd0,
    MUL_I = 2'd1,
    MUL_D = 2'd2
  } mul_sel_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_SUM,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     capture;
    logic     set_target;
    logic     step;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_load;
    logic     acc_add;
    logic     out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic touched;
    logic out_free;
  } dp_status_t;

endpackage

// ===== src/motor_fader_position_loop.sv =====
// Top level of the motor fader position loop.
// Joins mfpl_ctrl and mfpl_datapath; uses mfpl_pkg.
//
// Usage:
// - Input channel in_*: in_tuser selects the item kind (0 control tick,
//   1 set target). A set-target item loads the target, clears the
//   integral and last error, and produces no result.
// - A control tick produces one result on out_*: motor drive, duty and
//   the scaled fader position.
// - Configuration through cfg_we/cfg_addr/cfg_wdata, only while idle.
// - Sequencing: an untouched tick passes through the error, P, I and D
//   multiply, sum and output states; a touched tick goes from the
//   error state straight to the output state. A set-target item is
//   taken without leaving idle. The next item is taken in the cycle after the
//   result is loaded; the three PID terms use one multiplier in turn.
// - Reset (rst_n low, synchronous) clears the target and the loop state
//   and loads the register defaults; no result is pending after it.
// - When the receiver stalls, a finished result waits in the output
//   register; one more tick is taken and held at its last step until the
//   output register is free.

module motor_fader_position_loop #(
  parameter int ADC_BITS = mfpl_pkg::ADC_BITS_DEF,
  parameter int SUM_BITS = mfpl_pkg::SUM_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input channel.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // tdata fields from bit 0: target[7:0], adc_sample[ADC_BITS-1:0], touched.
  input  logic [((ADC_BITS+16)/8)*8-1:0]  in_tdata,
  // tuser fields from bit 0: mode.
  input  logic                            in_tuser,
  // Result channel.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // tdata fields from bit 0: drive[1:0], duty[7:0], position[6:0].
  output logic [mfpl_pkg::OUT_DATA_W-1:0] out_tdata,
  // Configuration write port.
  input  logic                            cfg_we,
  input  logic [mfpl_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [mfpl_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  mfpl_pkg::ctrl_cmd_t  cmd;
  mfpl_pkg::dp_status_t status;

  mfpl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  mfpl_datapath #(
    .ADC_BITS (ADC_BITS),
    .SUM_BITS (SUM_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // A result is only loaded when the output register is free.
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("result loaded over a pending result");

  // A loaded result appears on the output in the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_tvalid)
    else $error("loaded result not presented");

  // A tick transfer takes the block out of idle.
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == mfpl_pkg::MODE_TICK)) |=> !in_tready)
    else $error("input still ready after a tick transfer");

  // The drive field only carries the stop, up and down codes.
  a_drive_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[1:0] == mfpl_pkg::DRIVE_STOP) ||
                    (out_tdata[1:0] == mfpl_pkg::DRIVE_UP) ||
                    (out_tdata[1:0] == mfpl_pkg::DRIVE_DOWN)))
    else $error("invalid drive code");

endmodule

// ===== src/mfpl_ctrl.sv =====
// Controller state machine of the motor fader position loop.
// Sequences one item through the datapath; uses mfpl_pkg.

module mfpl_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tuser,
  output logic                   in_tready,
  input  mfpl_pkg::dp_status_t   status,
  output mfpl_pkg::ctrl_cmd_t    cmd
);

  mfpl_pkg::state_t state_r;
  mfpl_pkg::state_t state_nxt;
  logic             in_xfer;

  assign in_tready = (state_r == mfpl_pkg::ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mfpl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.mul_sel = mfpl_pkg::MUL_P;
    unique case (state_r)
      mfpl_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (in_tuser == mfpl_pkg::MODE_TARGET) begin
            cmd.set_target = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            state_nxt   = mfpl_pkg::ST_ERR;
          end
        end
      end
      mfpl_pkg::ST_ERR: begin
        // A touched fader skips the loop and leaves its state alone.
        if (status.touched) begin
          state_nxt = mfpl_pkg::ST_OUT;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = mfpl_pkg::ST_MUL_P;
        end
      end
      mfpl_pkg::ST_MUL_P: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mfpl_pkg::MUL_P;
        state_nxt   = mfpl_pkg::ST_MUL_I;
      end
      mfpl_pkg::ST_MUL_I: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = mfpl_pkg::MUL_I;
        cmd.acc_load = 1'b1;
        state_nxt    = mfpl_pkg::ST_MUL_D;
      end
      mfpl_pkg::ST_MUL_D: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mfpl_pkg::MUL_D;
        cmd.acc_add = 1'b1;
        state_nxt   = mfpl_pkg::ST_SUM;
      end
      mfpl_pkg::ST_SUM: begin
        cmd.acc_add = 1'b1;
        state_nxt   = mfpl_pkg::ST_OUT;
      end
      mfpl_pkg::ST_OUT: begin
        // Wait until the output register can take the result.
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = mfpl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mfpl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/mfpl_datapath.sv =====
// Datapath of the motor fader position loop: scaling, PID state,
// shared multiplier, accumulator, output shaping and config registers.
// Uses mfpl_pkg; driven by mfpl_ctrl.

module mfpl_datapath #(
  parameter int ADC_BITS = mfpl_pkg::ADC_BITS_DEF,
  parameter int SUM_BITS = mfpl_pkg::SUM_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mfpl_pkg::ctrl_cmd_t               cmd,
  output mfpl_pkg::dp_status_t              status,
  input  logic [((ADC_BITS+16)/8)*8-1:0]    in_tdata,
  input  logic                              cfg_we,
  input  logic [mfpl_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [mfpl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mfpl_pkg::OUT_DATA_W-1:0]   out_tdata
);

  localparam int X_W    = ADC_BITS + 7;
  localparam int PROD_W = 16 + SUM_BITS;
  localparam int ACC_W  = PROD_W + 2;
  localparam logic [ADC_BITS:0] ADC_FULL = {1'b0, {ADC_BITS{1'b1}}};

  // Configuration registers.
  logic signed [15:0] gain_p_r, gain_i_r, gain_d_r;
  logic [7:0]         limit_r, dead_r, min_duty_r;

  // PID state.
  logic [7:0]                 set_point_r;
  logic signed [SUM_BITS-1:0] sum_r;
  logic signed [8:0]          prev_r;

  // Per-item working registers.
  logic [6:0]                 pos_r;
  logic                       touched_r;
  logic signed [8:0]          err_r;
  logic signed [9:0]          deriv_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]    acc_r;

  // Output register.
  logic                           out_valid_r;
  logic [mfpl_pkg::OUT_DATA_W-1:0] out_data_r;

  // Input fields.
  logic [7:0]          in_target;
  logic [ADC_BITS-1:0] in_sample;
  logic                in_touched;

  assign in_target  = in_tdata[7:0];
  assign in_sample  = in_tdata[8 +: ADC_BITS];
  assign in_touched = in_tdata[8 + ADC_BITS];

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r   <= mfpl_pkg::GAIN_P_RST;
      gain_i_r   <= mfpl_pkg::GAIN_I_RST;
      gain_d_r   <= mfpl_pkg::GAIN_D_RST;
      limit_r    <= mfpl_pkg::OUT_LIMIT_RST;
      dead_r     <= mfpl_pkg::DEAD_BAND_RST;
      min_duty_r <= mfpl_pkg::MIN_DUTY_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        mfpl_pkg::CFG_GAIN_P:    gain_p_r   <= cfg_wdata;
        mfpl_pkg::CFG_GAIN_I:    gain_i_r   <= cfg_wdata;
        mfpl_pkg::CFG_GAIN_D:    gain_d_r   <= cfg_wdata;
        mfpl_pkg::CFG_OUT_LIMIT: limit_r    <= cfg_wdata[7:0];
        mfpl_pkg::CFG_DEAD_BAND: dead_r     <= cfg_wdata[7:0];
        mfpl_pkg::CFG_MIN_DUTY:  min_duty_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Position scaling: sample*127 / (2^N - 1). With x = q*2^N + lo, the
  // remainder by 2^N - 1 is lo + q, which is below twice the divisor.
  logic [X_W-1:0]    pos_x;
  logic [6:0]        pos_q;
  logic [ADC_BITS:0] pos_rem;
  logic [6:0]        pos_nxt;

  always_comb begin
    pos_x   = {in_sample, 7'd0} - X_W'(in_sample);
    pos_q   = pos_x[X_W-1 -: 7];
    pos_rem = {1'b0, pos_x[ADC_BITS-1:0]} + (ADC_BITS+1)'(pos_q);
    pos_nxt = (pos_rem >= ADC_FULL) ? pos_q + 7'd1 : pos_q;
  end

  // Error, saturating integral and derivative.
  logic signed [8:0]          err_nxt;
  logic signed [SUM_BITS:0]   sum_wide;
  logic signed [SUM_BITS-1:0] sum_nxt;
  logic signed [9:0]          deriv_nxt;

  always_comb begin
    err_nxt   = $signed({1'b0, set_point_r}) - $signed({2'b00, pos_r});
    sum_wide  = $signed({sum_r[SUM_BITS-1], sum_r}) + (SUM_BITS+1)'(err_nxt);
    deriv_nxt = $signed({err_nxt[8], err_nxt}) - $signed({prev_r[8], prev_r});
    if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
      sum_nxt = sum_wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                   : {1'b0, {(SUM_BITS-1){1'b1}}};
    end else begin
      sum_nxt = sum_wide[SUM_BITS-1:0];
    end
  end

  // Target, capture and loop state updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_point_r <= '0;
      sum_r       <= '0;
      prev_r      <= '0;
    end else if (cmd.set_target) begin
      set_point_r <= (in_target > mfpl_pkg::TARGET_MAX) ? mfpl_pkg::TARGET_MAX : in_target;
      sum_r       <= '0;
      prev_r      <= '0;
    end else if (cmd.step) begin
      sum_r  <= sum_nxt;
      prev_r <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pos_r     <= pos_nxt;
      touched_r <= in_touched;
    end
    if (cmd.step) begin
      err_r   <= err_nxt;
      deriv_r <= deriv_nxt;
    end
  end

  // Shared multiplier with a registered product.
  logic signed [15:0]         mul_a;
  logic signed [SUM_BITS-1:0] mul_b;

  always_comb begin
    unique case (cmd.mul_sel)
      mfpl_pkg::MUL_P: begin
        mul_a = gain_p_r;
        mul_b = SUM_BITS'(err_r);
      end
      mfpl_pkg::MUL_I: begin
        mul_a = gain_i_r;
        mul_b = sum_r;
      end
      mfpl_pkg::MUL_D: begin
        mul_a = gain_d_r;
        mul_b = SUM_BITS'(deriv_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (cmd.acc_load) begin
      acc_r <= ACC_W'(prod_r);
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // Floor shift, clamp, deadband and minimum duty.
  logic signed [ACC_W-1:0] shifted;
  logic signed [ACC_W-1:0] lim_pos;
  logic signed [ACC_W-1:0] lim_neg;
  logic signed [ACC_W-1:0] clamped;
  logic signed [8:0]       ctl;
  logic [8:0]              mag9;
  logic [7:0]              mag;
  mfpl_pkg::drive_t        drive;
  logic [7:0]              duty;

  always_comb begin
    shifted = acc_r >>> 8;
    lim_pos = $signed({{(ACC_W-8){1'b0}}, limit_r});
    lim_neg = -lim_pos;
    if (shifted > lim_pos) begin
      clamped = lim_pos;
    end else if (shifted < lim_neg) begin
      clamped = lim_neg;
    end else begin
      clamped = shifted;
    end
    ctl  = clamped[8:0];
    mag9 = ctl[8] ? 9'(-ctl) : 9'(ctl);
    mag  = mag9[7:0];
    if (touched_r || (mag < dead_r)) begin
      drive = mfpl_pkg::DRIVE_STOP;
      duty  = 8'd0;
    end else begin
      // An output of exactly zero that passes the deadband drives down.
      drive = (ctl > 9'sd0) ? mfpl_pkg::DRIVE_UP : mfpl_pkg::DRIVE_DOWN;
      duty  = (mag > min_duty_r) ? mag : min_duty_r;
    end
  end

  // Output register; a waiting result does not block the input side.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {7'd0, pos_r, duty, drive};
    end
  end

  assign out_tvalid      = out_valid_r;
  assign out_tdata       = out_data_r;
  assign status.touched  = touched_r;
  assign status.out_free = !out_valid_r || out_tready;

endmodule
